[hw/rtl/brt_pkg.sv]
// shared constants, types and helper functions of the bitmap rectangle engine
`default_nettype none
package brt_pkg;

  localparam int BITMAP_WIDTH  = 64;
  localparam int BITMAP_HEIGHT = 64;
  localparam int ROW_W         = 64;
  localparam int ADDR_W        = 6;
  localparam int CRD_W         = 7;
  localparam int CMD_W         = 4;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [CRD_W-1:0] crd_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE     = 4'd0,
    CMD_READ      = 4'd1,
    CMD_ROT_LEFT  = 4'd2,
    CMD_ROT_RIGHT = 4'd3,
    CMD_ROT_UP    = 4'd4,
    CMD_ROT_DOWN  = 4'd5,
    CMD_HFLIP     = 4'd6,
    CMD_VFLIP     = 4'd7,
    CMD_TRANSPOSE = 4'd8
  } cmd_e;

  typedef struct packed {
    logic push;
    logic pop;
  } buf_ctrl_t;

  function automatic row_t low_mask(crd_t n);
    row_t m;
    if (n >= CRD_W'(ROW_W)) begin
      m = '1;
    end else begin
      m = (row_t'(1) << n) - row_t'(1);
    end
    return m;
  endfunction

  function automatic crd_t clip(crd_t v, crd_t lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic row_t bit_rev(row_t v);
    row_t r;
    for (int k = 0; k < ROW_W; k++) begin
      r[k] = v[ROW_W-1-k];
    end
    return r;
  endfunction

  localparam row_t WIDTH_MASK = low_mask(CRD_W'(BITMAP_WIDTH));

endpackage
`default_nettype wire

[hw/rtl/brt_in_if.sv]
// input channel: one command word per handshake
`default_nettype none
interface brt_in_if;
  logic                       valid;
  logic                       ready;
  logic [brt_pkg::CMD_W-1:0]  cmd;
  logic [brt_pkg::ADDR_W-1:0] row_index;
  logic [brt_pkg::ROW_W-1:0]  row_pixels;
  logic [brt_pkg::CRD_W-1:0]  left_x;
  logic [brt_pkg::CRD_W-1:0]  top_y;
  logic [brt_pkg::CRD_W-1:0]  right_x;
  logic [brt_pkg::CRD_W-1:0]  bottom_y;

  modport source (output valid, cmd, row_index, row_pixels, left_x, top_y, right_x, bottom_y,
                  input ready);
  modport sink (input valid, cmd, row_index, row_pixels, left_x, top_y, right_x, bottom_y,
                output ready);
endinterface
`default_nettype wire

[hw/rtl/brt_out_if.sv]
// result channel: one result word per handshake
`default_nettype none
interface brt_out_if;
  logic                      valid;
  logic                      ready;
  logic [brt_pkg::ROW_W-1:0] read_pixels;
  logic                      was_read;

  modport source (output valid, read_pixels, was_read, input ready);
  modport sink (input valid, read_pixels, was_read, output ready);
endinterface
`default_nettype wire

[hw/rtl/brt_row_xform.sv]
// per-pixel lanes for in-row rotations and horizontal mirror, merged under the column mask
`default_nettype none
module brt_row_xform (
  input  logic [brt_pkg::CMD_W-1:0] op_i,
  input  brt_pkg::row_t             old_i,
  input  brt_pkg::crd_t             x0_i,
  input  brt_pkg::crd_t             x1_i,
  output brt_pkg::row_t             new_o
);
  import brt_pkg::*;

  crd_t           last;
  logic [CRD_W:0] mir_sum;
  logic [CRD_W:0] mir_sh;
  logic [2*ROW_W-1:0] mir_w;
  row_t cm;
  row_t rot_l;
  row_t rot_r;
  row_t sel;

  always_comb begin
    last    = x1_i - CRD_W'(1);
    cm      = low_mask(x1_i) & ~low_mask(x0_i);
    rot_l   = old_i >> 1;
    rot_l[last[ADDR_W-1:0]] = old_i[x0_i[ADDR_W-1:0]];
    rot_r   = old_i << 1;
    rot_r[x0_i[ADDR_W-1:0]] = old_i[last[ADDR_W-1:0]];
    // mirror: pixel x takes pixel x0+x1-1-x
    mir_sum = {1'b0, x0_i} + {1'b0, x1_i} - (CRD_W+1)'(1);
    mir_sh  = (CRD_W+1)'(2*ROW_W-1) - mir_sum;
    mir_w   = {bit_rev(old_i), {ROW_W{1'b0}}} >> mir_sh[CRD_W-1:0];
    unique case (op_i)
      CMD_ROT_LEFT:  sel = rot_l;
      CMD_ROT_RIGHT: sel = rot_r;
      CMD_HFLIP:     sel = mir_w[ROW_W-1:0];
      default:       sel = old_i;
    endcase
    new_o = (old_i & ~cm) | (sel & cm);
  end

endmodule
`default_nettype wire

[hw/rtl/brt_row_buf.sv]
// row stack for vertical mirror and transpose, with one column lane per stored row
`default_nettype none
module brt_row_buf (
  input  logic                       clk_i,
  input  brt_pkg::buf_ctrl_t         ctrl_i,
  input  brt_pkg::row_t              data_i,
  input  logic [brt_pkg::ADDR_W-1:0] col_i,
  input  brt_pkg::crd_t              n_i,
  input  brt_pkg::crd_t              x0_i,
  input  brt_pkg::row_t              old_i,
  output brt_pkg::row_t              head_o,
  output brt_pkg::row_t              tr_row_o
);
  import brt_pkg::*;

  row_t rows_q [BITMAP_HEIGHT];
  row_t col;
  row_t sq;
  row_t nmask;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      rows_q[0] <= data_i;
      for (int j = 1; j < BITMAP_HEIGHT; j++) begin
        rows_q[j] <= rows_q[j-1];
      end
    end else if (ctrl_i.pop) begin
      for (int j = 0; j < BITMAP_HEIGHT-1; j++) begin
        rows_q[j] <= rows_q[j+1];
      end
      rows_q[BITMAP_HEIGHT-1] <= '0;
    end
  end

  // stacked rows are newest first, so lane m holds square row n-1-m
  always_comb begin
    for (int m = 0; m < ROW_W; m++) begin
      col[m] = rows_q[m][col_i];
    end
    nmask    = low_mask(n_i);
    sq       = bit_rev(col) >> (CRD_W'(ROW_W) - n_i);
    tr_row_o = (old_i & ~(nmask << x0_i)) | ((sq & nmask) << x0_i);
    head_o   = rows_q[0];
  end

endmodule
`default_nettype wire

[hw/rtl/bitmap_rect_rotate_flip_transpose_core.sv]
// Bitmap rectangle engine top: a 64 by 64 one-bit bitmap in a row memory with one read port
// and one write port. A row write answers through the done state, a row read through the
// read-wait and done states. Rotate left/right and horizontal mirror make one pass over the
// rectangle's rows; rotate up/down add a tail state for the wrap row; vertical mirror and
// transpose load the rows into a row stack and then rewrite them in a second pass (over
// the square side's rows for a transpose). The memory takes one row read and one row
// write per cycle. A new command is taken while a finished result still waits at the output register.
`default_nettype none
module bitmap_rect_rotate_flip_transpose_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  brt_in_if.sink    in_i,
  brt_out_if.source out_o
);
  import brt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RDWAIT = 3'd1;
  localparam logic [2:0] S_PASS1  = 3'd2;
  localparam logic [2:0] S_TAIL   = 3'd3;
  localparam logic [2:0] S_PASS2  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_q, state_d;

  row_t                   mem [BITMAP_HEIGHT];
  row_t                   mem_rd_q;
  logic                   rd_vld_q;
  logic [BITMAP_HEIGHT-1:0] row_vld_q;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  row_t              wr_data;

  logic [CMD_W-1:0]  op_q;
  crd_t              x0_q, x1_q, y0_q, y1_q, len_q, n_q, cnt_q;
  logic              p_vld_q;
  logic [ADDR_W-1:0] p_addr_q, p_idx_q, prev_addr_q;
  row_t              prev_row_q, first_q, res_pixels_q;
  logic              res_read_q;
  logic              out_vld_q;
  row_t              out_pixels_q;
  logic              out_read_q;

  logic      accept;
  crd_t      cx0, cx1, cy0, cy1, cw, ch, cn;
  row_t      rd_row, cm, xf_row, head_row, tr_row;
  logic      issue, pass_end, out_free;
  crd_t      iss_addr;
  buf_ctrl_t buf_ctrl;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;

  assign out_o.valid       = out_vld_q;
  assign out_o.read_pixels = out_pixels_q;
  assign out_o.was_read    = out_read_q;

  always_comb begin
    cx0 = clip(in_i.left_x, CRD_W'(BITMAP_WIDTH));
    cx1 = clip(in_i.right_x, CRD_W'(BITMAP_WIDTH));
    cy0 = clip(in_i.top_y, CRD_W'(BITMAP_HEIGHT));
    cy1 = clip(in_i.bottom_y, CRD_W'(BITMAP_HEIGHT));
    cw  = cx1 - cx0;
    ch  = cy1 - cy0;
    cn  = (cw < ch) ? cw : ch;
  end

  assign rd_row   = rd_vld_q ? mem_rd_q : '0;
  assign cm       = low_mask(x1_q) & ~low_mask(x0_q);
  assign issue    = ((state_q == S_PASS1) || (state_q == S_PASS2)) && (cnt_q < len_q);
  assign pass_end = (cnt_q == len_q) && !p_vld_q;

  // rotate down walks the rows bottom up, everything else top down
  assign iss_addr = ((state_q == S_PASS1) && (op_q == CMD_ROT_DOWN)) ?
                    (y1_q - CRD_W'(1) - cnt_q) : (y0_q + cnt_q);

  always_comb begin
    if (state_q == S_IDLE) begin
      rd_en   = accept && (in_i.cmd == CMD_READ);
      rd_addr = in_i.row_index;
    end else begin
      rd_en   = issue;
      rd_addr = iss_addr[ADDR_W-1:0];
    end
  end

  brt_row_xform u_xform (
    .op_i  (op_q),
    .old_i (rd_row),
    .x0_i  (x0_q),
    .x1_i  (x1_q),
    .new_o (xf_row)
  );

  assign buf_ctrl.push = p_vld_q && (state_q == S_PASS1) &&
                         ((op_q == CMD_VFLIP) || (op_q == CMD_TRANSPOSE));
  assign buf_ctrl.pop  = p_vld_q && (state_q == S_PASS2) && (op_q == CMD_VFLIP);

  brt_row_buf u_buf (
    .clk_i    (clk_i),
    .ctrl_i   (buf_ctrl),
    .data_i   ((op_q == CMD_TRANSPOSE) ? (rd_row >> x0_q) : rd_row),
    .col_i    (p_idx_q),
    .n_i      (n_q),
    .x0_i     (x0_q),
    .old_i    (rd_row),
    .head_o   (head_row),
    .tr_row_o (tr_row)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p_addr_q;
    wr_data = xf_row;
    if (accept && (in_i.cmd == CMD_WRITE)) begin
      wr_en   = 1'b1;
      wr_addr = in_i.row_index;
      wr_data = in_i.row_pixels & WIDTH_MASK;
    end else if (state_q == S_TAIL) begin
      wr_en   = 1'b1;
      wr_addr = prev_addr_q;
      wr_data = (prev_row_q & ~cm) | first_q;
    end else if (p_vld_q && (state_q == S_PASS1)) begin
      if ((op_q == CMD_ROT_LEFT) || (op_q == CMD_ROT_RIGHT) || (op_q == CMD_HFLIP)) begin
        wr_en = 1'b1;
      end else if (((op_q == CMD_ROT_UP) || (op_q == CMD_ROT_DOWN)) && (p_idx_q != '0)) begin
        // the row before takes this row's rectangle columns
        wr_en   = 1'b1;
        wr_addr = prev_addr_q;
        wr_data = (prev_row_q & ~cm) | (rd_row & cm);
      end
    end else if (p_vld_q && (state_q == S_PASS2)) begin
      wr_en   = 1'b1;
      wr_data = (op_q == CMD_VFLIP) ? ((rd_row & ~cm) | (head_row & cm)) : tr_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_rd_q <= mem[rd_addr];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.cmd == CMD_WRITE) begin
            state_d = S_DONE;
          end else if (in_i.cmd == CMD_READ) begin
            state_d = S_RDWAIT;
          end else if ((in_i.cmd > CMD_TRANSPOSE) || (cx1 <= cx0) || (cy1 <= cy0) ||
                       ((in_i.cmd == CMD_TRANSPOSE) && (cn < CRD_W'(2)))) begin
            state_d = S_DONE;
          end else begin
            state_d = S_PASS1;
          end
        end
      end
      S_RDWAIT: state_d = S_DONE;
      S_PASS1: begin
        if (pass_end) begin
          if ((op_q == CMD_ROT_UP) || (op_q == CMD_ROT_DOWN)) begin
            state_d = S_TAIL;
          end else if ((op_q == CMD_VFLIP) || (op_q == CMD_TRANSPOSE)) begin
            state_d = S_PASS2;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_TAIL: state_d = S_DONE;
      S_PASS2: begin
        if (pass_end) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      cnt_q     <= '0;
      p_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        row_vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= row_vld_q[rd_addr];
      end
      if (accept) begin
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + CRD_W'(1);
      end else if ((state_q == S_PASS1) && pass_end) begin
        cnt_q <= '0;
      end
      p_vld_q <= issue;
      if (out_o.valid && out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if ((state_q == S_DONE) && out_free) begin
        out_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q         <= in_i.cmd;
      x0_q         <= cx0;
      x1_q         <= cx1;
      y0_q         <= cy0;
      y1_q         <= cy1;
      n_q          <= cn;
      len_q        <= (in_i.cmd == CMD_TRANSPOSE) ? cn : ch;
      res_pixels_q <= '0;
      res_read_q   <= 1'b0;
    end
    p_addr_q <= rd_addr;
    p_idx_q  <= cnt_q[ADDR_W-1:0];
    if (state_q == S_RDWAIT) begin
      res_pixels_q <= rd_row & WIDTH_MASK;
      res_read_q   <= 1'b1;
    end
    if (p_vld_q && (state_q == S_PASS1) && ((op_q == CMD_ROT_UP) || (op_q == CMD_ROT_DOWN))) begin
      prev_row_q  <= rd_row;
      prev_addr_q <= p_addr_q;
      if (p_idx_q == '0) begin
        first_q <= rd_row & cm;
      end
    end
    if ((state_q == S_DONE) && out_free) begin
      out_pixels_q <= res_pixels_q;
      out_read_q   <= res_read_q;
    end
  end

endmodule
`default_nettype wire

[sim/bitmap_rect_rotate_flip_transpose_checker.sv]
// checker: bitmap predictor and result scoreboard for the rectangle engine
module bitmap_rect_rotate_flip_transpose_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [brt_pkg::CMD_W-1:0]  cmd_i,
  input  logic [brt_pkg::ADDR_W-1:0] row_index_i,
  input  brt_pkg::row_t              row_pixels_i,
  input  brt_pkg::crd_t              left_x_i,
  input  brt_pkg::crd_t              top_y_i,
  input  brt_pkg::crd_t              right_x_i,
  input  brt_pkg::crd_t              bottom_y_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  brt_pkg::row_t              read_pixels_i,
  input  logic                       was_read_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import brt_pkg::*;

  typedef struct packed {
    row_t pixels;
    logic was_read;
  } answer_t;

  row_t    bitmap [BITMAP_HEIGHT];
  answer_t answers [$];
  int      fails;

  assign fail_count_o = fails;
  assign pending_o    = answers.size();

  function automatic row_t span_mask(int lo, int hi);
    row_t m;
    m = '0;
    for (int k = lo; k < hi; k++) m[k] = 1'b1;
    return m;
  endfunction

  function automatic int lim(crd_t v, int top);
    return (int'(v) > top) ? top : int'(v);
  endfunction

  // applies one command word to the bitmap copy and returns its answer
  function automatic answer_t apply_command(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] ri,
                                            row_t px, crd_t lx, crd_t ty, crd_t rx, crd_t by);
    answer_t a;
    row_t    cm, keep, r;
    logic    t;
    int      x0, y0, x1, y1, n;
    a  = '0;
    x0 = lim(lx, BITMAP_WIDTH);
    y0 = lim(ty, BITMAP_HEIGHT);
    x1 = lim(rx, BITMAP_WIDTH);
    y1 = lim(by, BITMAP_HEIGHT);
    if (cmd == CMD_WRITE) begin
      bitmap[ri] = px;
      return a;
    end
    if (cmd == CMD_READ) begin
      a.pixels   = bitmap[ri];
      a.was_read = 1'b1;
      return a;
    end
    if (cmd > CMD_TRANSPOSE || x1 <= x0 || y1 <= y0) return a;
    cm = span_mask(x0, x1);
    case (cmd_e'(cmd))
      CMD_ROT_LEFT: begin
        for (int y = y0; y < y1; y++) begin
          r = bitmap[y];
          t = r[x0];
          for (int x = x0; x + 1 < x1; x++) r[x] = r[x+1];
          r[x1-1] = t;
          bitmap[y] = r;
        end
      end
      CMD_ROT_RIGHT: begin
        for (int y = y0; y < y1; y++) begin
          r = bitmap[y];
          t = r[x1-1];
          for (int x = x1 - 1; x > x0; x--) r[x] = r[x-1];
          r[x0] = t;
          bitmap[y] = r;
        end
      end
      CMD_ROT_UP: begin
        keep = bitmap[y0] & cm;
        for (int y = y0; y + 1 < y1; y++) bitmap[y] = (bitmap[y] & ~cm) | (bitmap[y+1] & cm);
        bitmap[y1-1] = (bitmap[y1-1] & ~cm) | keep;
      end
      CMD_ROT_DOWN: begin
        keep = bitmap[y1-1] & cm;
        for (int y = y1 - 1; y > y0; y--) bitmap[y] = (bitmap[y] & ~cm) | (bitmap[y-1] & cm);
        bitmap[y0] = (bitmap[y0] & ~cm) | keep;
      end
      CMD_HFLIP: begin
        for (int y = y0; y < y1; y++) begin
          r = bitmap[y];
          for (int i = 0; i < (x1 - x0) / 2; i++) begin
            t = r[x0+i];
            r[x0+i] = r[x1-1-i];
            r[x1-1-i] = t;
          end
          bitmap[y] = r;
        end
      end
      CMD_VFLIP: begin
        for (int i = 0; i < (y1 - y0) / 2; i++) begin
          keep = bitmap[y0+i] & cm;
          bitmap[y0+i] = (bitmap[y0+i] & ~cm) | (bitmap[y1-1-i] & cm);
          bitmap[y1-1-i] = (bitmap[y1-1-i] & ~cm) | keep;
        end
      end
      default: begin
        n = (x1 - x0 < y1 - y0) ? x1 - x0 : y1 - y0;
        for (int i = 0; i < n; i++) begin
          for (int j = i + 1; j < n; j++) begin
            t = bitmap[y0+i][x0+j];
            bitmap[y0+i][x0+j] = bitmap[y0+j][x0+i];
            bitmap[y0+j][x0+i] = t;
          end
        end
      end
    endcase
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t got, want;
    if (!rst_ni) begin
      for (int k = 0; k < BITMAP_HEIGHT; k++) bitmap[k] = '0;
      answers.delete();
      fails = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        answers.push_back(apply_command(cmd_i, row_index_i, row_pixels_i, left_x_i, top_y_i,
                                        right_x_i, bottom_y_i));
      end
      if (out_valid_i && out_ready_i) begin
        got = {read_pixels_i, was_read_i};
        if (answers.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result word: pixels %h was_read %b",
                                    got.pixels, got.was_read);
        end else begin
          want = answers.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10) $display("result mismatch: expected %h/%b, got %h/%b",
                                      want.pixels, want.was_read, got.pixels, got.was_read);
          end
        end
      end
    end
  end
endmodule

[sim/bitmap_rect_rotate_flip_transpose_core_test.sv]
// testbench top: command stimulus, idle phases and verdict for the rectangle engine
module bitmap_rect_rotate_flip_transpose_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import brt_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct;
  int   recv_stall_pct;
  bit   hold_off;
  bit   stim_done;
  int   fail_count;
  int   pending;
  int   quiet_cycles;

  brt_in_if  cmd_ch ();
  brt_out_if res_ch ();

  bitmap_rect_rotate_flip_transpose_core i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_ch.sink),
    .out_o (res_ch.source)
  );

  bitmap_rect_rotate_flip_transpose_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (cmd_ch.valid),
    .in_ready_i   (cmd_ch.ready),
    .cmd_i        (cmd_ch.cmd),
    .row_index_i  (cmd_ch.row_index),
    .row_pixels_i (cmd_ch.row_pixels),
    .left_x_i     (cmd_ch.left_x),
    .top_y_i      (cmd_ch.top_y),
    .right_x_i    (cmd_ch.right_x),
    .bottom_y_i   (cmd_ch.bottom_y),
    .out_valid_i  (res_ch.valid),
    .out_ready_i  (res_ch.ready),
    .read_pixels_i(res_ch.read_pixels),
    .was_read_i   (res_ch.was_read),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic row_t rand_row();
    return {$urandom(), $urandom()};
  endfunction

  function automatic crd_t rand_crd();
    // mostly in range, sometimes beyond the bitmap edge
    return ($urandom_range(0, 9) == 0) ? crd_t'($urandom_range(0, 127))
                                       : crd_t'($urandom_range(0, 64));
  endfunction

  // valid stays high between back-to-back words and drops only while idling
  task automatic send_word(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] ri, row_t px,
                           crd_t lx, crd_t ty, crd_t rx, crd_t by);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.cmd        <= cmd;
    cmd_ch.row_index  <= ri;
    cmd_ch.row_pixels <= px;
    cmd_ch.left_x     <= lx;
    cmd_ch.top_y      <= ty;
    cmd_ch.right_x    <= rx;
    cmd_ch.bottom_y   <= by;
    do @(posedge clk_i); while (!cmd_ch.ready);
  endtask

  task automatic send_random();
    int   pick;
    crd_t lx, ty;
    pick = $urandom_range(0, 99);
    lx   = rand_crd();
    ty   = rand_crd();
    if (pick < 25) begin
      send_word(CMD_WRITE, ADDR_W'($urandom()), rand_row(), rand_crd(), rand_crd(),
                rand_crd(), rand_crd());
    end else if (pick < 45) begin
      send_word(CMD_READ, ADDR_W'($urandom()), rand_row(), rand_crd(), rand_crd(),
                rand_crd(), rand_crd());
    end else if (pick < 97) begin
      // small rectangles most of the time to keep operations short
      send_word(CMD_W'($urandom_range(CMD_ROT_LEFT, CMD_TRANSPOSE)), ADDR_W'($urandom()),
                rand_row(), lx, ty,
                ($urandom_range(0, 3) == 0) ? rand_crd() : crd_t'(lx + $urandom_range(0, 12)),
                ($urandom_range(0, 3) == 0) ? rand_crd() : crd_t'(ty + $urandom_range(0, 12)));
    end else begin
      send_word(CMD_W'($urandom_range(9, 15)), ADDR_W'($urandom()), rand_row(), rand_crd(),
                rand_crd(), rand_crd(), rand_crd());
    end
  endtask

  // receiver ready: random stalls, plus a long hold-off on request
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_ch.ready <= !hold_off &&
                      !(recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct);
    end
  end

  initial begin
    int hold_cycles;
    hold_off = 1'b0;
    wait (stim_done == 1'b0 && send_idle_pct == 0 && rst_ni);
    repeat (300) @(posedge clk_i);
    hold_off    = 1'b1;
    hold_cycles = 0;
    while (hold_cycles < 600) begin
      @(posedge clk_i);
      hold_cycles++;
    end
    hold_off = 1'b0;
  end

  // watchdog on cycles with no handshake at all
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || hold_off) begin
        quiet_cycles = 0;
      end else if (pending > 0 || !stim_done) begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int fill_row;
    stim_done         = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    rst_ni            = 1'b0;
    cmd_ch.valid      = 1'b0;
    cmd_ch.cmd        = CMD_WRITE;
    cmd_ch.row_index  = '0;
    cmd_ch.row_pixels = '0;
    cmd_ch.left_x     = '0;
    cmd_ch.top_y      = '0;
    cmd_ch.right_x    = '0;
    cmd_ch.bottom_y   = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, each command, clipping and degenerate rectangles
    send_word(CMD_READ, 6'd63, '0, '0, '0, '0, '0);
    send_word(CMD_WRITE, 6'd0, '1, '0, '0, '0, '0);
    send_word(CMD_WRITE, 6'd63, 64'h8000_0000_0000_0001, 7'd127, 7'd127, 7'd127, 7'd127);
    send_word(CMD_WRITE, 6'd5, 64'hdead_beef_0123_4567, '0, '0, '0, '0);
    send_word(CMD_ROT_LEFT, 6'd0, '0, 7'd0, 7'd0, 7'd127, 7'd127);
    send_word(CMD_ROT_RIGHT, 6'd0, '0, 7'd3, 7'd2, 7'd40, 7'd64);
    send_word(CMD_ROT_UP, 6'd0, '0, 7'd0, 7'd0, 7'd64, 7'd64);
    send_word(CMD_ROT_DOWN, 6'd0, '0, 7'd7, 7'd1, 7'd9, 7'd63);
    send_word(CMD_HFLIP, 6'd0, '0, 7'd1, 7'd0, 7'd64, 7'd64);
    send_word(CMD_VFLIP, 6'd0, '0, 7'd0, 7'd0, 7'd64, 7'd64);
    send_word(CMD_TRANSPOSE, 6'd0, '0, 7'd0, 7'd0, 7'd64, 7'd64);
    send_word(CMD_TRANSPOSE, 6'd0, '0, 7'd60, 7'd2, 7'd64, 7'd40);
    send_word(CMD_ROT_LEFT, 6'd0, '0, 7'd10, 7'd10, 7'd10, 7'd20);
    send_word(CMD_VFLIP, 6'd0, '0, 7'd10, 7'd20, 7'd30, 7'd5);
    send_word(CMD_HFLIP, 6'd0, '0, 7'd4, 7'd0, 7'd5, 7'd64);
    send_word(CMD_ROT_UP, 6'd0, '0, 7'd0, 7'd9, 7'd64, 7'd10);
    send_word(CMD_TRANSPOSE, 6'd0, '0, 7'd5, 7'd5, 7'd6, 7'd30);
    send_word(4'd9, 6'd3, '1, 7'd0, 7'd0, 7'd64, 7'd64);
    send_word(4'd15, 6'd3, '1, 7'd127, 7'd0, 7'd64, 7'd64);
    for (fill_row = 0; fill_row < 64; fill_row += 21)
      send_word(CMD_READ, ADDR_W'(fill_row), '0, '0, '0, '0, '0);

    // random phases: none, sender idle, receiver stall, both
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 84 : (phase == 3) ? 36 : 0;
      recv_stall_pct = (phase == 2) ? 84 : (phase == 3) ? 36 : 0;
      for (int k = 0; k < 430; k++) send_random();
      // random-phase reads keep the bitmap observable between phases
      for (fill_row = 0; fill_row < 64; fill_row += 9)
        send_word(CMD_READ, ADDR_W'(fill_row), '0, '0, '0, '0, '0);
    end
    cmd_ch.valid   <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    stim_done      = 1'b1;

    while (pending > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
